/* design/rcsf_pkg.sv */
`default_nettype none

package rcsf_pkg;

  // Default table depth for the top level parameter.
  localparam int MAX_STOPS_DEFAULT = 16;

  // Channel and register widths for the top level; the checker uses M_DATA_W.
  localparam int COUNT_W  = 5;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 24;

  // Level driven on all three colors when no stop is in use.
  localparam logic [7:0] GREY_LEVEL = 8'd32;

  // Request kinds carried on s_tuser.
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_RD_CUR = 6'b000010,
    ST_RD_NXT = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

endpackage

`default_nettype wire

/* design/rgb_color_stop_fade_sequencer.sv */
//  Channel  Dir  Signals                        Contents (lowest bit first)
//  s_*      in   s_tvalid s_tready s_tdata      stop_index[3:0] red[11:4] green[19:12]
//                s_tuser                        blue[27:20] duration[43:28], zero pad
//                                               s_tuser: mode (0 tick, 1 load)
//  m_*      out  m_tvalid m_tready m_tdata      red_out[7:0] green_out[15:8] blue_out[23:16]
//  cfg_*    in   cfg_wr_en cfg_wr_data          stop_count[4:0]
//
//  A load request leaves the block idle and ready. A tick request that fades
//  keeps the block busy for two reads of the single-port stop table, then for
//  each of the three colors one multiply state and the steps of the shared
//  restore-and-subtract divider, then the emit state, which moves the result
//  into the output register. A tick that only advances to the next stop goes
//  through both reads back to idle; with no stops in use a tick goes straight
//  to the emit state. The output register lets a new request in while a result
//  waits; a finished result stalls in the last state only while the register
//  is full. Reset is synchronous and clears the control state and the stop
//  count. The stop table has no reset and needs no clearing pass.

`default_nettype none

module rgb_color_stop_fade_sequencer #(
  parameter int MAX_STOPS = rcsf_pkg::MAX_STOPS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // stop_index[3:0], red[11:4], green[19:12], blue[27:20], duration[43:28]
  input  wire logic [rcsf_pkg::S_DATA_W-1:0] s_tdata,
  // mode[0]
  input  wire logic                         s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [rcsf_pkg::M_DATA_W-1:0]     m_tdata,
  input  wire logic                         cfg_wr_en,
  input  wire logic [rcsf_pkg::COUNT_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

  // One table entry: duration in the top bits, then blue, green, red.
  localparam int ENTRY_W = 40;

  rcsf_pkg::state_t state;

  logic [rcsf_pkg::COUNT_W-1:0] stop_count;
  logic [IDX_W-1:0]             cur;
  logic [15:0]                  elapsed;
  logic [1:0]                   col;
  logic [2:0]                   step;

  // Datapath registers.
  logic [IDX_W-1:0]   nxt;
  logic [23:0]        cur_rgb;
  logic [23:0]        nx_rgb;
  logic [15:0]        dur;
  logic               neg;
  logic [25:0]        rem;
  logic [23:0]        dsr;
  logic [7:0]         quo;
  logic [23:0]        res;

  // Stop table.
  logic [ENTRY_W-1:0] stop_mem [MAX_STOPS];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;

  // Request decode.
  logic        s_acc;
  logic        is_load;
  logic [3:0]  in_index;
  logic [31:0] count32;
  logic [31:0] nxt32;
  logic        no_stops;
  logic        cur_oor;
  logic [IDX_W-1:0] cur_eff;
  logic [IDX_W-1:0] nxt_eff;

  // Shared arithmetic.
  logic [7:0]         cur_c;
  logic [7:0]         nx_c;
  logic signed [8:0]  diff;
  logic signed [25:0] prod;
  logic [26:0]        num;
  logic [25:0]        mag;
  logic               ge;
  logic [7:0]         quo_new;
  logic [7:0]         level;
  logic [15:0]        elapsed_inc;
  logic               out_free;
  logic               nx_reached;

  assign s_tready = (state == rcsf_pkg::ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign is_load  = (s_tuser == rcsf_pkg::MODE_LOAD);
  assign in_index = s_tdata[3:0];

  // A stop count above the table size is treated as the table size.
  assign count32  = (32'(stop_count) > MAX_STOPS) ? MAX_STOPS : 32'(stop_count);
  assign no_stops = (count32 == 32'd0);
  assign cur_oor  = (32'(cur) >= count32);
  assign cur_eff  = cur_oor ? '0 : cur;
  assign nxt32    = 32'(cur_eff) + 32'd1;
  assign nxt_eff  = (nxt32 == count32) ? '0 : nxt32[IDX_W-1:0];

  assign mem_we  = s_acc && is_load && (32'(in_index) < MAX_STOPS);
  assign rd_addr = (state == rcsf_pkg::ST_RD_CUR) ? nxt : cur_eff;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stop_mem[IDX_W'(in_index)] <= {s_tdata[43:28], s_tdata[27:20], s_tdata[19:12],
                                     s_tdata[11:4]};
    end
    rd_data <= stop_mem[rd_addr];
  end

  // The next stop has been reached when the elapsed count meets its duration.
  assign nx_reached = (elapsed >= rd_data[39:24]);

  // Signed color step times elapsed ticks, doubled, plus the duration: the
  // rounded fraction is then an integer division by twice the duration.
  assign cur_c = cur_rgb[{col, 3'b000} +: 8];
  assign nx_c  = nx_rgb[{col, 3'b000} +: 8];
  assign diff  = $signed({1'b0, nx_c}) - $signed({1'b0, cur_c});
  assign prod  = diff * $signed({1'b0, elapsed});
  assign num   = {prod, 1'b0} + {11'd0, dur};
  assign mag   = num[26] ? (~num[25:0] + 26'd1) : num[25:0];

  // One restoring division step; the quotient is truncated toward zero and
  // then given the sign of the numerator.
  assign ge      = (rem >= {2'b00, dsr});
  assign quo_new = {quo[6:0], ge};
  assign level   = cur_c + (neg ? (~quo_new + 8'd1) : quo_new);

  assign elapsed_inc = elapsed + 16'd1;
  assign out_free    = !m_tvalid || m_tready;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rcsf_pkg::ST_IDLE;
      stop_count <= '0;
      cur        <= '0;
      elapsed    <= '0;
      col        <= '0;
      step       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        stop_count <= cfg_wr_data;
      end
      // A new result replaces a taken one in the same cycle.
      if ((state == rcsf_pkg::ST_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        rcsf_pkg::ST_IDLE: begin
          if (s_acc) begin
            if (is_load) begin
              cur     <= '0;
              elapsed <= '0;
            end else if (no_stops) begin
              state <= rcsf_pkg::ST_EMIT;
            end else begin
              if (cur_oor) begin
                cur     <= '0;
                elapsed <= '0;
              end
              state <= rcsf_pkg::ST_RD_CUR;
            end
          end
        end
        rcsf_pkg::ST_RD_CUR: begin
          state <= rcsf_pkg::ST_RD_NXT;
        end
        rcsf_pkg::ST_RD_NXT: begin
          if (nx_reached) begin
            elapsed <= '0;
            cur     <= nxt;
            state   <= rcsf_pkg::ST_IDLE;
          end else begin
            col   <= '0;
            state <= rcsf_pkg::ST_MUL;
          end
        end
        rcsf_pkg::ST_MUL: begin
          step  <= 3'd7;
          state <= rcsf_pkg::ST_DIV;
        end
        rcsf_pkg::ST_DIV: begin
          step <= step - 3'd1;
          if (step == 3'd0) begin
            if (col == 2'd2) begin
              if (elapsed_inc >= dur) begin
                elapsed <= '0;
                cur     <= nxt;
              end else begin
                elapsed <= elapsed_inc;
              end
              state <= rcsf_pkg::ST_EMIT;
            end else begin
              col   <= col + 2'd1;
              state <= rcsf_pkg::ST_MUL;
            end
          end
        end
        rcsf_pkg::ST_EMIT: begin
          if (out_free) begin
            state <= rcsf_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= rcsf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (s_acc && !is_load) begin
      nxt <= nxt_eff;
      res <= {rcsf_pkg::GREY_LEVEL, rcsf_pkg::GREY_LEVEL, rcsf_pkg::GREY_LEVEL};
    end
    if (state == rcsf_pkg::ST_RD_CUR) begin
      cur_rgb <= rd_data[23:0];
    end
    if (state == rcsf_pkg::ST_RD_NXT) begin
      nx_rgb <= rd_data[23:0];
      dur    <= rd_data[39:24];
    end
    if (state == rcsf_pkg::ST_MUL) begin
      // The first quotient bit weighs 128 times twice the duration.
      neg <= num[26];
      rem <= mag;
      dsr <= {dur, 8'd0};
      quo <= '0;
    end
    if (state == rcsf_pkg::ST_DIV) begin
      if (ge) begin
        rem <= rem - {2'b00, dsr};
      end
      dsr <= dsr >> 1;
      quo <= quo_new;
      if (step == 3'd0) begin
        res[{col, 3'b000} +: 8] <= level;
      end
    end
    if ((state == rcsf_pkg::ST_EMIT) && out_free) begin
      m_tdata <= res;
    end
  end

endmodule

`default_nettype wire

/* design/rcsf_checker.sv */
`default_nettype none

module rcsf_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         s_tuser,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [rcsf_pkg::M_DATA_W-1:0] m_tdata
);

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A tick request keeps the block busy for at least the next cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == rcsf_pkg::MODE_TICK) |=> !s_tready)
    else $error("tick request did not occupy the sequencer");

  // A load request never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == rcsf_pkg::MODE_LOAD) && !m_tvalid |=> !m_tvalid)
    else $error("load request produced a result");

  // Reset leaves no result pending and the block ready.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind rgb_color_stop_fade_sequencer rcsf_checker u_rcsf_checker (
  .clk        (clk),
  .rst        (rst),
  .s_tvalid   (s_tvalid),
  .s_tready   (s_tready),
  .s_tuser    (s_tuser),
  .m_tvalid   (m_tvalid),
  .m_tready   (m_tready),
  .m_tdata    (m_tdata)
);

`default_nettype wire
